@@ rtl/tcsw_pkg.sv @@
// Package for the text console scroll writer.
// Holds field widths, default geometry, codes and the controller/datapath
// command and status structs. No dependencies.
package tcsw_pkg;

  // Default screen geometry
  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  // Field widths of the item ports
  localparam int CODE_W  = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 8;

  // Character and cell constants
  localparam logic [CODE_W-1:0]  NEWLINE_CODE     = 8'd10;
  localparam logic [CODE_W-1:0]  BLANK_CODE       = 8'h20;
  localparam logic [CELL_W-1:0]  RESET_CELL       = 16'h0720;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'd7;

  // Command field codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_PUT,
    ST_FINISH
  } tcsw_state_t;

  typedef enum logic [1:0] {
    ADDR_HOLD,
    ADDR_ZERO,
    ADDR_INC
  } addr_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_BLANK,
    WR_CHAR
  } wr_kind_t;

  typedef struct packed {
    logic     capture;
    addr_op_t addr_op;
    logic     copy_rd;
    logic     rd_cell;
    wr_kind_t wr;
    logic     cursor_zero;
    logic     cursor_inc;
    logic     mark_scroll;
    logic     load_out;
  } tcsw_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_newline;
    logic cursor_full;
    logic copy_last;
    logic fill_last;
  } tcsw_status_t;

endpackage

@@ rtl/text_console_scroll_writer_top.sv @@
// Top level of the text console scroll writer.
// Instantiates tcsw_ctrl and tcsw_datapath; uses tcsw_pkg.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  input    | in_valid / in_ready | command, char_code, read_row, read_column
//  output   | out_valid/out_ready | cell_value, cursor_column, scrolled
//  config   | cfg_valid/cfg_ready | cfg_data (text_color attribute)
//
// After reset the block sweeps all ROWS*COLS cells of the store to blank cells,
// one cell per cycle, and takes no item meanwhile; cfg writes are taken at any time.
// A read or a plain character write runs from idle through decode, then read
// or put, then finish, where its result is loaded into the output register; the
// next item is accepted only once the block is back in idle.
// A scroll (newline or full line) walks the store through its single read
// and write ports: it copies (ROWS-1)*COLS cells up one row, takes a drain
// step and blanks the COLS cells of the bottom row; a character that lands on a
// full line is then written in a put step.
// One item is in work at a time; its result waits in the output register
// while the next item runs, and that next item is held in its last step
// until the earlier result is taken.
module text_console_scroll_writer_top
  import tcsw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF,
  localparam int CW  = $clog2(COLS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  // config write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COLOR_W-1:0] cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [CODE_W-1:0]  char_code,
  input  logic [ROW_W-1:0]   read_row,
  input  logic [COL_W-1:0]   read_column,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CELL_W-1:0]  cell_value,
  output logic [CW-1:0]      cursor_column,
  output logic               scrolled
);

  tcsw_cmd_t    cmd;
  tcsw_status_t status;

  // The color register takes a write in any cycle
  assign cfg_ready = 1'b1;

  tcsw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tcsw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .command       (command),
    .char_code     (char_code),
    .read_row      (read_row),
    .read_column   (read_column),
    .cell_value    (cell_value),
    .cursor_column (cursor_column),
    .scrolled      (scrolled)
  );

endmodule

@@ rtl/tcsw_ctrl.sv @@
// Controller of the text console scroll writer: state machine that
// sequences clear, read, scroll and character write. Uses tcsw_pkg.
module tcsw_ctrl
  import tcsw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  tcsw_status_t status,
  output tcsw_cmd_t    cmd
);

  tcsw_state_t state;
  tcsw_state_t state_next;
  logic        out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.fill_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (status.is_read) begin
          state_next = ST_READ;
        end else if (status.is_newline || status.cursor_full) begin
          state_next = ST_COPY;
        end else begin
          state_next = ST_PUT;
        end
      end
      ST_READ:  state_next = ST_FINISH;
      ST_COPY: begin
        if (status.copy_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_FILL;
      ST_FILL: begin
        if (status.fill_last) state_next = status.is_newline ? ST_FINISH : ST_PUT;
      end
      ST_PUT:   state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '{capture: 1'b0, addr_op: ADDR_HOLD, copy_rd: 1'b0, rd_cell: 1'b0,
            wr: WR_NONE, cursor_zero: 1'b0, cursor_inc: 1'b0,
            mark_scroll: 1'b0, load_out: 1'b0};
    unique case (state)
      ST_CLEAR: begin
        cmd.wr      = WR_CLEAR;
        cmd.addr_op = ADDR_INC;
      end
      ST_IDLE: begin
        cmd.capture = in_valid;
      end
      ST_DECODE: begin
        if (!status.is_read && (status.is_newline || status.cursor_full)) begin
          cmd.addr_op     = ADDR_ZERO;
          cmd.cursor_zero = 1'b1;
          cmd.mark_scroll = 1'b1;
        end
      end
      ST_READ: begin
        cmd.rd_cell = 1'b1;
      end
      ST_COPY: begin
        cmd.copy_rd = 1'b1;
        cmd.addr_op = ADDR_INC;
      end
      ST_DRAIN: begin
      end
      ST_FILL: begin
        cmd.wr      = WR_BLANK;
        cmd.addr_op = ADDR_INC;
      end
      ST_PUT: begin
        cmd.wr         = WR_CHAR;
        cmd.cursor_inc = 1'b1;
      end
      ST_FINISH: begin
        cmd.load_out = out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/tcsw_datapath.sv @@
// Datapath of the text console scroll writer: cell store, address counter,
// cursor, captured item, color register and result register. Uses tcsw_pkg.
module tcsw_datapath
  import tcsw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF,
  localparam int CW  = $clog2(COLS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  tcsw_cmd_t          cmd,
  output tcsw_status_t       status,
  input  logic               cfg_valid,
  input  logic [COLOR_W-1:0] cfg_data,
  input  logic               command,
  input  logic [CODE_W-1:0]  char_code,
  input  logic [ROW_W-1:0]   read_row,
  input  logic [COL_W-1:0]   read_column,
  output logic [CELL_W-1:0]  cell_value,
  output logic [CW-1:0]      cursor_column,
  output logic               scrolled
);

  localparam int CELLS     = ROWS * COLS;
  localparam int AW        = $clog2(CELLS);
  localparam int BOTTOM    = (ROWS - 1) * COLS;
  localparam int COPY_LAST = BOTTOM - 1;

  logic [CELL_W-1:0]  mem [CELLS];
  logic [CELL_W-1:0]  rd_data;
  logic [AW-1:0]      addr;
  logic               copy_valid;
  logic [AW-1:0]      copy_addr;
  logic [CW-1:0]      cursor;
  logic               scroll_flag;
  logic [COLOR_W-1:0] text_color;

  logic               command_q;
  logic [CODE_W-1:0]  code_q;
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;

  logic               in_range;
  logic [AW-1:0]      cell_addr;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [CELL_W-1:0]  wdata;

  assign in_range  = (32'(row_q) < 32'(ROWS)) && (32'(col_q) < 32'(COLS));
  assign cell_addr = AW'(row_q) * AW'(COLS) + AW'(col_q);
  assign raddr     = cmd.copy_rd ? (addr + AW'(COLS)) : cell_addr;

  assign status.is_read     = (command_q == CMD_READ);
  assign status.is_newline  = (code_q == NEWLINE_CODE);
  assign status.cursor_full = (cursor == CW'(COLS));
  assign status.copy_last   = (addr == AW'(COPY_LAST));
  assign status.fill_last   = (addr == AW'(CELLS - 1));

  // Write port: a pending copy write wins; the controller never overlaps them
  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = RESET_CELL;
    if (copy_valid) begin
      we    = 1'b1;
      waddr = copy_addr;
      wdata = rd_data;
    end else begin
      case (cmd.wr)
        WR_CLEAR: begin
          we    = 1'b1;
          wdata = RESET_CELL;
        end
        WR_BLANK: begin
          we    = 1'b1;
          wdata = {text_color, BLANK_CODE};
        end
        WR_CHAR: begin
          we    = 1'b1;
          waddr = AW'(BOTTOM) + AW'(cursor);
          wdata = {text_color, code_q};
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.copy_rd || cmd.rd_cell) rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr        <= '0;
      copy_valid  <= 1'b0;
      cursor      <= '0;
      scroll_flag <= 1'b0;
      text_color  <= TEXT_COLOR_RESET;
    end else begin
      case (cmd.addr_op)
        ADDR_ZERO: addr <= '0;
        ADDR_INC:  addr <= status.fill_last ? '0 : addr + 1'b1;
        default:   addr <= addr;
      endcase
      copy_valid <= cmd.copy_rd;
      if (cmd.cursor_zero) begin
        cursor <= '0;
      end else if (cmd.cursor_inc) begin
        cursor <= cursor + 1'b1;
      end
      if (cmd.capture) begin
        scroll_flag <= 1'b0;
      end else if (cmd.mark_scroll) begin
        scroll_flag <= 1'b1;
      end
      if (cfg_valid) text_color <= cfg_data;
    end
  end

  // Captured item and result payload
  always_ff @(posedge clk) begin
    copy_addr <= addr;
    if (cmd.capture) begin
      command_q <= command;
      code_q    <= char_code;
      row_q     <= read_row;
      col_q     <= read_column;
    end
    if (cmd.load_out) begin
      cell_value    <= (status.is_read && in_range) ? rd_data : '0;
      cursor_column <= cursor;
      scrolled      <= scroll_flag;
    end
  end

endmodule

@@ tb/tcsw_console_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the text console scroll writer.
// Watches the config, input and result channels and predicts each result.
// Depends on tcsw_pkg.
module tcsw_console_checker
  import tcsw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF,
  localparam int CW  = $clog2(COLS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [COLOR_W-1:0] cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               command,
  input  logic [CODE_W-1:0]  char_code,
  input  logic [ROW_W-1:0]   read_row,
  input  logic [COL_W-1:0]   read_column,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [CELL_W-1:0]  cell_value,
  input  logic [CW-1:0]      cursor_column,
  input  logic               scrolled,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic [CELL_W-1:0] cell_word;
    logic [CW-1:0]     column;
    logic              scroll;
  } console_result_t;

  logic [CELL_W-1:0]  screen_copy [ROWS*COLS];
  logic [CW-1:0]      cursor_copy;
  logic [COLOR_W-1:0] attr_copy;
  console_result_t    results_due [$];

  // Move every row up and blank the bottom row with the current attribute.
  task automatic scroll_screen();
    for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
      screen_copy[i] = screen_copy[i + COLS];
    end
    for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++) begin
      screen_copy[i] = {attr_copy, BLANK_CODE};
    end
    cursor_copy = '0;
  endtask

  task automatic apply_console_item(input logic cmd, input logic [CODE_W-1:0] code,
                                    input logic [ROW_W-1:0] row,
                                    input logic [COL_W-1:0] col,
                                    output console_result_t res);
    res = '0;
    if (cmd == CMD_READ) begin
      if (row < ROWS && col < COLS) begin
        res.cell_word = screen_copy[int'(row) * COLS + int'(col)];
      end
    end else if (code == NEWLINE_CODE) begin
      scroll_screen();
      res.scroll = 1'b1;
    end else begin
      if (cursor_copy >= COLS) begin
        scroll_screen();
        res.scroll = 1'b1;
      end
      screen_copy[(ROWS - 1) * COLS + int'(cursor_copy)] = {attr_copy, code};
      cursor_copy = cursor_copy + 1'b1;
    end
    res.column = cursor_copy;
  endtask

  always @(posedge clk) begin : watch_channels
    console_result_t want;
    console_result_t got;
    if (rst) begin
      for (int i = 0; i < ROWS * COLS; i++) begin
        screen_copy[i] = RESET_CELL;
      end
      cursor_copy = '0;
      attr_copy   = TEXT_COLOR_RESET;
      fail_count  = 0;
      results_due.delete();
    end else begin
      // Results first: they belong to items taken on earlier edges.
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected: cell %h column %0d scrolled %0b",
                   $time, cell_value, cursor_column, scrolled);
        end else begin
          want = results_due.pop_front();
          got  = {cell_value, cursor_column, scrolled};
          if (got.cell_word !== want.cell_word) begin
            fail_count++;
            $display("%0t: cell_value expected %h, actual %h", $time, want.cell_word,
                     got.cell_word);
          end
          if (got.column !== want.column) begin
            fail_count++;
            $display("%0t: cursor_column expected %0d, actual %0d",
                     $time, want.column, got.column);
          end
          if (got.scroll !== want.scroll) begin
            fail_count++;
            $display("%0t: scrolled expected %0b, actual %0b", $time, want.scroll, got.scroll);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        attr_copy = cfg_data;
      end
      if (in_valid && in_ready) begin
        apply_console_item(command, char_code, read_row, read_column, want);
        results_due.push_back(want);
      end
    end
    pending_count = results_due.size();
  end

endmodule

@@ tb/text_console_scroll_writer_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the text console scroll writer: clock, reset, stimulus,
// result stalls, watchdog and verdict. Depends on tcsw_pkg, the block's RTL
// and tcsw_console_checker.
module text_console_scroll_writer_top_tb;
  import tcsw_pkg::*;

  localparam int LAST_ROW        = ROWS_DEF - 1;
  localparam int LAST_COL        = COLS_DEF - 1;
  localparam int CW              = $clog2(COLS_DEF + 1);
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 250;
  // A scroll walks the whole cell store, and so does the clearing sweep after
  // reset; allow several times the worst quiet stretch.
  localparam int QUIET_LIMIT     = 20000;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COLOR_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               command;
  logic [CODE_W-1:0]  char_code;
  logic [ROW_W-1:0]   read_row;
  logic [COL_W-1:0]   read_column;
  logic               out_valid;
  logic               out_ready;
  logic [CELL_W-1:0]  cell_value;
  logic [CW-1:0]      cursor_column;
  logic               scrolled;

  int fail_count;
  int pending_count;
  int items_sent   = 0;
  int quiet_cycles = 0;
  // When set, neither side inserts idle cycles.
  bit calm         = 1'b0;

  text_console_scroll_writer_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .char_code    (char_code),
    .read_row     (read_row),
    .read_column  (read_column),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_value   (cell_value),
    .cursor_column(cursor_column),
    .scrolled     (scrolled)
  );

  tcsw_console_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .char_code    (char_code),
    .read_row     (read_row),
    .read_column  (read_column),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_value   (cell_value),
    .cursor_column(cursor_column),
    .scrolled     (scrolled),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: take results, except for random stall bursts while not calm.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item, hold it until taken, then maybe drop valid for a burst.
  task automatic send_item(input logic cmd, input logic [CODE_W-1:0] code,
                           input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    int unsigned gap;
    @(negedge clk);
    in_valid    <= 1'b1;
    command     <= cmd;
    char_code   <= code;
    read_row    <= row;
    read_column <= col;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    // every item answers, so the block is already idle once the last result is taken
    repeat (4) @(negedge clk);
  endtask

  task automatic write_color(input logic [COLOR_W-1:0] attr);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= attr;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random burst: runs of text most often, some newlines, reads (half of them
  // aimed at the lower rows where the text lands), and a little raw noise.
  task automatic random_burst();
    int unsigned pick;
    int unsigned run;
    logic [CODE_W-1:0] glyph;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // long runs can overflow the line and force the wrap scroll
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 100) : $urandom_range(1, 30);
      repeat (run) begin
        glyph = CODE_W'($urandom_range(0, 255));
        if (glyph == NEWLINE_CODE) glyph = BLANK_CODE;
        send_item(CMD_WRITE, glyph, ROW_W'($urandom), COL_W'($urandom));
      end
    end else if (pick < 60) begin
      send_item(CMD_WRITE, NEWLINE_CODE, ROW_W'($urandom), COL_W'($urandom));
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0:       send_item(CMD_READ, CODE_W'($urandom), ROW_W'($urandom),
                             COL_W'($urandom));
          1:       send_item(CMD_READ, CODE_W'($urandom), ROW_W'($urandom_range(0, LAST_ROW)),
                             COL_W'($urandom_range(0, LAST_COL)));
          default: send_item(CMD_READ, CODE_W'($urandom),
                             ROW_W'($urandom_range(LAST_ROW - 2, LAST_ROW)),
                             COL_W'($urandom_range(0, LAST_COL)));
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_item(1'($urandom), CODE_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    logic [COLOR_W-1:0] attr;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    command     = CMD_WRITE;
    char_code   = '0;
    read_row    = '0;
    read_column = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, reset attribute in force.
    send_item(CMD_READ, '0, ROW_W'(LAST_ROW), '0);                 // blank left by reset
    send_item(CMD_WRITE, 8'h41, '0, '0);
    send_item(CMD_WRITE, 8'h00, '0, '0);                           // lowest code
    send_item(CMD_WRITE, 8'hFF, '0, '0);                           // highest code
    send_item(CMD_READ, '0, ROW_W'(LAST_ROW), '0);
    send_item(CMD_READ, '0, ROW_W'(LAST_ROW), COL_W'(2));
    send_item(CMD_READ, '0, ROW_W'(LAST_ROW), COL_W'(LAST_COL));
    send_item(CMD_READ, '0, '0, '0);
    send_item(CMD_READ, '0, '0, COL_W'(LAST_COL));
    send_item(CMD_READ, '0, ROW_W'(ROWS_DEF), '0);                 // row past the screen
    send_item(CMD_READ, 8'hFF, 5'h1F, 7'h7F);         // all ones, both out of range
    send_item(CMD_READ, '0, '0, COL_W'(COLS_DEF));                 // column past the screen
    send_item(CMD_READ, '0, ROW_W'(LAST_ROW), 7'h7F);
    send_item(CMD_READ, NEWLINE_CODE, ROW_W'(LAST_ROW), COL_W'(1)); // newline code: no scroll
    send_item(CMD_WRITE, 8'h0B, 5'h1F, 7'h7F);        // read fields ignored on a write
    send_item(CMD_WRITE, NEWLINE_CODE, 5'h1F, 7'h7F);
    send_item(CMD_READ, '0, ROW_W'(LAST_ROW - 1), '0);             // text moved up one row
    send_item(CMD_READ, '0, ROW_W'(LAST_ROW), '0);                 // fresh blank bottom row
    send_item(CMD_WRITE, NEWLINE_CODE, '0, '0);                    // newline at column 0
    send_item(CMD_READ, '0, ROW_W'(LAST_ROW - 2), COL_W'(1));
    send_item(CMD_WRITE, BLANK_CODE, '0, '0);
    send_item(CMD_WRITE, 8'h7F, '0, '0);
    send_item(CMD_WRITE, 8'h80, '0, '0);
    send_item(CMD_READ, '0, ROW_W'(LAST_ROW), COL_W'(1));
    send_item(CMD_READ, '0, ROW_W'(LAST_ROW), COL_W'(2));

    // Random part: one attribute per phase, extremes first. Each phase change
    // waits for every result, then old cells and new blanks mix colors.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       attr = 8'hFF;
        1:       attr = 8'h00;
        2:       attr = 8'h1E;
        3:       attr = COLOR_W'($urandom_range(0, 255));
        default: attr = TEXT_COLOR_RESET;
      endcase
      // a calm phase in the middle, and the last one calm throughout
      calm <= (phase == 2) || (phase == PHASES - 1);
      write_color(attr);
      while (items_sent < 25 + (phase + 1) * ITEMS_PER_PHASE) random_burst();
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
